@@ sv/mbd_pkg.sv @@
// Shared constants, types and lane-averaging function for the mipmap box downsampler.
package mbd_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W     = COL_W + 1;
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 16;
   localparam int LANE_W    = 8;
   localparam int LANES     = 4;
   localparam int PIXEL_W   = LANE_W * LANES;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef logic [PIXEL_W-1:0] pixel_type;

   function automatic pixel_type avg_lanes(input pixel_type a, input pixel_type b);
      logic [LANE_W:0] sum;
      pixel_type       res;
      res = '0;
      for (int k = 0; k < LANES; k++) begin
         sum = {1'b0, a[k*LANE_W +: LANE_W]} + {1'b0, b[k*LANE_W +: LANE_W]} + 1'b1;
         res[k*LANE_W +: LANE_W] = sum[LANE_W:1];
      end
      return res;
   endfunction

endpackage

@@ sv/mipmap_box_downsample.sv @@
// Top level of the 2x2 box-filter mipmap downsampler for 4-byte pixels.
// Accepts one pixel per cycle in raster order and emits one averaged pixel per 2x2 block
// via the stage-1 registers and the result register once its bottom-right pixel is taken.
// The line store is one memory of MAX_WIDTH 32-bit words with one write and one registered
// read per cycle; the request side stalls only while a finished result waits on the
// response side. Odd last columns and rows are consumed without output. Write image_width
// and image_height only while no pixel is in flight.
module mipmap_box_downsample
   import mbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [COL_W-1:0]    column_count_ff, column_count_in;
   logic [HEIGHT_W-1:0] row_count_ff, row_count_in;

   logic [CNT_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [CNT_W-1:0]    last_x;
   logic [HEIGHT_W-1:0] last_y;
   logic [CNT_W-1:0]    x_next;
   logic [HEIGHT_W:0]   y_next;
   logic                in_range;
   logic                advance;
   logic                req_accept;

   pixel_type           row_mem [MAX_WIDTH];
   pixel_type           above_ff;
   pixel_type           pix_ff;
   logic                s1_valid_ff;
   logic                s1_odd_col_ff;
   logic                s1_last_ff;
   pixel_type           held_ff;
   pixel_type           vert_avg;
   pixel_type           box_avg;

   logic                rsp_valid_ff;
   pixel_type           rsp_data_ff;
   logic                rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_W'(2048);
         image_height_ff <= HEIGHT_W'(2048);
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else if (image_width_ff < WIDTH_W'(2)) begin
         w_eff = CNT_W'(2);
      end else begin
         w_eff = CNT_W'(image_width_ff);
      end
      if (image_height_ff < HEIGHT_W'(2)) begin
         h_eff = HEIGHT_W'(2);
      end else begin
         h_eff = image_height_ff;
      end
      last_x   = (w_eff & ~CNT_W'(1)) - CNT_W'(1);
      last_y   = (h_eff & ~HEIGHT_W'(1)) - HEIGHT_W'(1);
      x_next   = {1'b0, column_count_ff} + CNT_W'(1);
      y_next   = {1'b0, row_count_ff} + (HEIGHT_W+1)'(1);
      in_range = ({1'b0, column_count_ff} < w_eff) && (row_count_ff < h_eff);
      if (x_next >= w_eff) begin
         column_count_in = '0;
         row_count_in    = (y_next >= {1'b0, h_eff}) ? '0 : y_next[HEIGHT_W-1:0];
      end else begin
         column_count_in = x_next[COL_W-1:0];
         row_count_in    = row_count_ff;
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (req_accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // line store: write top row, read for bottom row
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (in_range && !row_count_ff[0]) begin
            row_mem[column_count_ff] <= req_tdata;
         end
         above_ff <= row_mem[column_count_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept && in_range && row_count_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff        <= req_tdata;
         s1_odd_col_ff <= column_count_ff[0];
         s1_last_ff    <= ({1'b0, column_count_ff} == last_x) && (row_count_ff == last_y);
      end
   end

   assign vert_avg = avg_lanes(above_ff, pix_ff);
   assign box_avg  = avg_lanes(held_ff, vert_avg);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (advance && s1_valid_ff && !s1_odd_col_ff) begin
         held_ff <= vert_avg;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && s1_odd_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_odd_col_ff) begin
         rsp_data_ff <= box_avg;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
